/* hw/rtl/hyperloglog_register_sketch_top_defines.svh */
// Assertion macros for the HyperLogLog register sketch.
// HLL_ASSERT checks a condition at every clock edge outside reset.
// HLL_ASSERT_NEXT checks that a condition holds in the cycle after another.
`ifndef HYPERLOGLOG_REGISTER_SKETCH_TOP_DEFINES_SVH
`define HYPERLOGLOG_REGISTER_SKETCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HLL_ASSERT(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("hll: assertion failed");
`define HLL_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("hll: assertion failed");
`else
`define HLL_ASSERT(label, ck, rn, prop)
`define HLL_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

/* hw/rtl/hll_pkg.sv */
`default_nettype none

package hll_pkg;

    localparam int OPCODE_W  = 2;
    localparam int HASH_W    = 64;
    localparam int INDEX_W   = 14;
    localparam int RANK_W    = 6;
    localparam int SUM_W     = 63;
    localparam int ZCOUNT_W  = 15;
    localparam int FRAC_BITS = 48;

    localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [ZCOUNT_W-1:0] ZCOUNT_MAX = {ZCOUNT_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_MERGE     = 2'd1,
        OP_READ      = 2'd2,
        OP_SUMMARIZE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_SUM_RUN,
        BK_SUM_LAST
    } back_state_t;

    function automatic logic [3:0] lead_zeros8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

    // Leading zeros of a 64-bit word, found per byte and then per word.
    function automatic logic [6:0] lead_zeros64(input logic [63:0] v);
        logic [6:0] n;
        logic [7:0] b;
        n = 7'd64;
        for (int k = 7; k >= 0; k--)
        begin
            b = v[63 - 8 * k -: 8];
            if (|b)
            begin
                n = 7'(8 * k) + 7'(lead_zeros8(b));
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hll_front.sv */
`default_nettype none

module hll_front #(
    parameter int PRECISION = 14
) (
    input  logic                          push,
    output logic                          full,
    input  logic [hll_pkg::OPCODE_W-1:0]  opcode,
    input  logic [hll_pkg::HASH_W-1:0]    hash_value,
    input  logic [hll_pkg::INDEX_W-1:0]   reg_index,
    input  logic [hll_pkg::RANK_W-1:0]    reg_value,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          q_push,
    output hll_pkg::opcode_t              q_op,
    output logic [PRECISION-1:0]          q_addr,
    output logic [hll_pkg::RANK_W-1:0]    q_val
);
    import hll_pkg::*;

    opcode_t                       op;
    logic [HASH_W-1:0]             rest;
    logic [6:0]                    lz;
    logic [RANK_W-1:0]             rank;
    logic [INDEX_W+PRECISION-1:0]  index_ext;

    assign op     = opcode_t'(opcode);
    assign full   = q_full || clearing;
    assign q_push = push && !full;

    // The bits below the register index decide the rank; all zero gives the top rank.
    assign rest = hash_value << PRECISION;
    assign lz   = lead_zeros64(rest);
    assign rank = (rest == '0) ? RANK_W'(HASH_W + 1 - PRECISION) : RANK_W'(lz + 7'd1);

    assign index_ext = {{PRECISION{1'b0}}, reg_index};

    always_comb
    begin
        q_op = op;
        if (op == OP_INSERT)
        begin
            q_addr = hash_value[HASH_W-1 -: PRECISION];
            q_val  = rank;
        end
        else
        begin
            q_addr = index_ext[PRECISION-1:0];
            q_val  = reg_value;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hll_queue.sv */
`default_nettype none

module hll_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    output logic             q_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    assign q_full  = (count_reg == (AW + 1)'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hll_back.sv */
`default_nettype none

module hll_back #(
    parameter int PRECISION = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  hll_pkg::opcode_t               q_op,
    input  logic [PRECISION-1:0]           q_addr,
    input  logic [hll_pkg::RANK_W-1:0]     q_val,
    output logic                           q_pop,
    output logic                           clearing,
    input  logic                           pop,
    output logic                           empty,
    output logic [hll_pkg::RANK_W-1:0]     reg_value_out,
    output logic [hll_pkg::SUM_W-1:0]      harmonic_sum,
    output logic [hll_pkg::ZCOUNT_W-1:0]   zero_count
);
    import hll_pkg::*;

    localparam int NUM_REGS = 1 << PRECISION;

    logic [RANK_W-1:0]    mem [NUM_REGS];
    logic [RANK_W-1:0]    rdata_reg;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [PRECISION-1:0] idx_cnt_reg;
    logic [PRECISION-1:0] idx_cnt_next;
    logic                 acc_en_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    opcode_t              cur_op_reg;
    logic [PRECISION-1:0] cur_addr_reg;
    logic [RANK_W-1:0]    cur_val_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [ZCOUNT_W-1:0]  zero_reg;
    logic [RANK_W-1:0]    out_rv_reg;
    logic [SUM_W-1:0]     out_sum_reg;
    logic [ZCOUNT_W-1:0]  out_zc_reg;

    logic                 idx_last;
    logic                 out_pop;
    logic                 out_free;
    logic                 dispatch;
    logic [RANK_W-1:0]    merged;
    logic [SUM_W-1:0]     term;
    logic [SUM_W:0]       sum_add;
    logic [SUM_W-1:0]     sum_next;
    logic [ZCOUNT_W-1:0]  zero_next;

    logic                 mem_we;
    logic [PRECISION-1:0] mem_waddr;
    logic [PRECISION-1:0] mem_raddr;
    logic [RANK_W-1:0]    mem_wdata;
    logic                 load_out;
    logic [RANK_W-1:0]    load_rv;
    logic [SUM_W-1:0]     load_sum;
    logic [ZCOUNT_W-1:0]  load_zc;

    assign idx_last = &idx_cnt_reg;
    assign out_pop  = pop && out_valid_reg;
    assign out_free = !out_valid_reg || out_pop;
    assign dispatch = (state_reg == BK_IDLE) && q_valid && out_free;
    assign q_pop    = dispatch;
    assign clearing = (state_reg == BK_CLEAR);

    assign empty         = !out_valid_reg;
    assign reg_value_out = out_rv_reg;
    assign harmonic_sum  = out_sum_reg;
    assign zero_count    = out_zc_reg;

    assign merged = (cur_val_reg > rdata_reg) ? cur_val_reg : rdata_reg;

    // Ranks above the fraction width contribute terms below one LSB and are dropped.
    always_comb
    begin
        if (rdata_reg <= RANK_W'(FRAC_BITS))
        begin
            term = SUM_W'(1) << (RANK_W'(FRAC_BITS) - rdata_reg);
        end
        else
        begin
            term = '0;
        end
    end

    // A carry out of the sum means it passed the largest value; it then sticks there.
    assign sum_add  = {1'b0, sum_reg} + {1'b0, term};
    assign sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign zero_next = ((rdata_reg == '0) && (zero_reg != ZCOUNT_MAX)) ?
                       zero_reg + ZCOUNT_W'(1) : zero_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (idx_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (dispatch)
                begin
                    state_next = (q_op == OP_SUMMARIZE) ? BK_SUM_RUN : BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            BK_SUM_RUN:
            begin
                if (idx_last)
                begin
                    state_next = BK_SUM_LAST;
                end
            end
            BK_SUM_LAST:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr_reg;
        mem_wdata = merged;
        mem_raddr = q_addr;
        load_out  = 1'b0;
        load_rv   = '0;
        load_sum  = '0;
        load_zc   = '0;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_cnt_reg;
                mem_wdata = '0;
            end
            BK_EXEC:
            begin
                mem_we   = (cur_op_reg != OP_READ) && (cur_val_reg > rdata_reg);
                load_out = 1'b1;
                load_rv  = (cur_op_reg == OP_READ) ? rdata_reg : merged;
            end
            BK_SUM_RUN:
            begin
                mem_raddr = idx_cnt_reg;
            end
            BK_SUM_LAST:
            begin
                load_out = 1'b1;
                load_sum = sum_next;
                load_zc  = zero_next;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_cnt_next = idx_cnt_reg;
        if ((state_reg == BK_CLEAR) || (state_reg == BK_SUM_RUN))
        begin
            idx_cnt_next = idx_cnt_reg + 1'b1;
        end
        else if (dispatch)
        begin
            idx_cnt_next = '0;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            idx_cnt_reg   <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_cnt_reg   <= idx_cnt_next;
            acc_en_reg    <= (state_reg == BK_SUM_RUN);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dispatch)
        begin
            cur_op_reg   <= q_op;
            cur_addr_reg <= q_addr;
            cur_val_reg  <= q_val;
        end
        if (dispatch)
        begin
            sum_reg  <= '0;
            zero_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            sum_reg  <= sum_next;
            zero_reg <= zero_next;
        end
        if (load_out)
        begin
            out_rv_reg  <= load_rv;
            out_sum_reg <= load_sum;
            out_zc_reg  <= load_zc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/hyperloglog_register_sketch_top.sv */
// HyperLogLog register sketch with 2^PRECISION six-bit rank registers.
// Items enter through a queue-like port: an item transfers when push is high and
// full is low. Opcodes are insert of a 64-bit hash, merge of one register by
// maximum, read of one register, and summarize over all registers.
// Every item produces exactly one result, which waits on the result ports while
// empty is low and transfers when pop is high. Results come out in item order.
// With the back end idle, insert, merge and read pass from the command queue
// through the back end's read register into the result register. The back end
// reads the register in the cycle it takes an item and writes it in the next,
// then returns to idle before it takes another, so it does not take a new item
// until it is through with the last one.
// Summarize walks the memory one register per cycle; it returns the zero count
// and the sum of 2^-rank in Q15.48. After reset the memory is cleared one entry
// per cycle; full stays high until that pass is done.
// A stalled receiver holds the result register; the command queue keeps taking
// items until it fills, then full goes high.
`default_nettype none
`include "hyperloglog_register_sketch_top_defines.svh"

module hyperloglog_register_sketch_top #(
    parameter int PRECISION = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [hll_pkg::OPCODE_W-1:0]  opcode,
    input  logic [hll_pkg::HASH_W-1:0]    hash_value,
    input  logic [hll_pkg::INDEX_W-1:0]   reg_index,
    input  logic [hll_pkg::RANK_W-1:0]    reg_value,
    output logic                          empty,
    input  logic                          pop,
    output logic [hll_pkg::RANK_W-1:0]    reg_value_out,
    output logic [hll_pkg::SUM_W-1:0]     harmonic_sum,
    output logic [hll_pkg::ZCOUNT_W-1:0]  zero_count
);
    import hll_pkg::*;

    localparam int QW          = OPCODE_W + PRECISION + RANK_W;
    localparam int QUEUE_DEPTH = 2;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_valid;
    logic                 clearing;
    opcode_t              fr_op;
    logic [PRECISION-1:0] fr_addr;
    logic [RANK_W-1:0]    fr_val;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;
    opcode_t              hd_op;
    logic [PRECISION-1:0] hd_addr;
    logic [RANK_W-1:0]    hd_val;

    hll_front #(
        .PRECISION (PRECISION)
    ) u_front (
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .hash_value (hash_value),
        .reg_index  (reg_index),
        .reg_value  (reg_value),
        .q_full     (q_full),
        .clearing   (clearing),
        .q_push     (q_push),
        .q_op       (fr_op),
        .q_addr     (fr_addr),
        .q_val      (fr_val)
    );

    assign q_wdata = {fr_op, fr_addr, fr_val};

    hll_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .q_valid (q_valid),
        .rd_en   (q_pop),
        .rd_data (q_rdata)
    );

    assign hd_op   = opcode_t'(q_rdata[QW-1 -: OPCODE_W]);
    assign hd_addr = q_rdata[RANK_W +: PRECISION];
    assign hd_val  = q_rdata[RANK_W-1:0];

    hll_back #(
        .PRECISION (PRECISION)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_op          (hd_op),
        .q_addr        (hd_addr),
        .q_val         (hd_val),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .pop           (pop),
        .empty         (empty),
        .reg_value_out (reg_value_out),
        .harmonic_sum  (harmonic_sum),
        .zero_count    (zero_count)
    );

    `HLL_ASSERT(a_full_while_clearing, clk, rst_n, !clearing || full)
    `HLL_ASSERT(a_no_result_while_clearing, clk, rst_n, !(clearing && !empty))
    `HLL_ASSERT(a_summary_fields_apart, clk, rst_n, empty || (zero_count == '0) || (reg_value_out == '0))
    `HLL_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push, q_valid)

endmodule

`default_nettype wire
